// ----- rtl/true_wind_from_apparent_assert.svh -----
// Assertion macros used by the checker of the true wind block.
`ifndef TRUE_WIND_FROM_APPARENT_ASSERT_SVH
`define TRUE_WIND_FROM_APPARENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWFA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("true wind block: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("true wind block: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define TWFA_ASSERT_RESET(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("true wind block: reset check failed");

`endif

// ----- rtl/twfa_pkg.sv -----
// Shared constants, types and helper functions of the true wind block.
package twfa_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int FRACTION_BITS  = 8;

    localparam int ANGLE_W        = 12;
    localparam int SPEED_IN_W     = 11;
    localparam int SPEED_W        = 12;

    // Integer bits of the datapath words, sign included.
    localparam int INT_W          = 14;
    localparam int VW             = INT_W + FRACTION_BITS;
    localparam int SPD_RAW_W      = INT_W + 1;

    localparam int GAIN_W         = 25;
    localparam int GAIN_SHIFT     = 24;
    localparam int PW             = VW + GAIN_W;
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 25'sd10188014;

    localparam int ATAN_TABLE_LEN = 24;
    localparam int ATAN_IDX_W     = 5;
    localparam int ATAN_Q         = 16;
    localparam int ATAN_SUM_W     = 26;
    localparam int ATAN_SHIFT     = ATAN_Q - FRACTION_BITS;
    localparam int ATAN_HALF      = (1 << ATAN_SHIFT) >> 1;

    // atan(2^-i) in tenths of a degree, Q16.
    localparam logic [24:0] ATAN_Q16 [ATAN_TABLE_LEN] = '{
        25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451,
        25'd2343786,  25'd1173036,  25'd586661,  25'd293348,
        25'd146676,   25'd73339,    25'd36669,   25'd18335,
        25'd9167,     25'd4584,     25'd2292,    25'd1146,
        25'd573,      25'd286,      25'd143,     25'd72,
        25'd36,       25'd18,       25'd9,       25'd4
    };

    localparam logic [ANGLE_W-1:0] ANGLE_WRAP    = 12'd3600;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 12'd900;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER = 12'd2700;
    localparam logic signed [INT_W-1:0] FULL_TURN = 14'sd3600;
    localparam logic signed [INT_W-1:0] HALF_TURN = 14'sd1800;
    localparam logic [SPEED_W-1:0] SPEED_MAX     = 12'd4095;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic [ANGLE_W-1:0]    apparent_angle;
        logic [SPEED_IN_W-1:0] apparent_speed;
        logic [SPEED_IN_W-1:0] ground_speed;
        logic [ANGLE_W-1:0]    measured_angle;
        logic [SPEED_W-1:0]    measured_speed;
    } t_in_item;

    // Facts about one item that ride along with the CORDIC pipeline.
    typedef struct packed {
        logic [SPEED_IN_W-1:0] ground_speed;
        logic                  force_zero;
        logic                  angle_pass;
        logic [ANGLE_W-1:0]    angle_meas;
        logic                  speed_pass;
        logic [SPEED_W-1:0]    speed_meas;
    } t_side;

    typedef struct packed {
        logic [ANGLE_W-1:0] true_angle;
        logic [SPEED_W-1:0] true_speed;
        logic               angle_passed_through;
        logic               speed_passed_through;
    } t_out_item;

    // Arctangent step rounded half up to FRACTION_BITS fraction bits.
    function automatic t_vec atan_step(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_SUM_W-1:0] sum;
        sum = ATAN_SUM_W'(ATAN_Q16[idx]) + ATAN_SUM_W'(ATAN_HALF);
        return t_vec'(sum >> ATAN_SHIFT);
    endfunction

    // Brings a 12-bit angle code above 3599 back into range.
    function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
        return (a >= ANGLE_WRAP) ? (a - ANGLE_WRAP) : a;
    endfunction

endpackage

// ----- rtl/twfa_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
interface twfa_in_if;
    logic                               valid;
    logic                               ready;
    logic [twfa_pkg::ANGLE_W-1:0]       apparent_angle;
    logic [twfa_pkg::SPEED_IN_W-1:0]    apparent_speed;
    logic [twfa_pkg::SPEED_IN_W-1:0]    ground_speed;
    logic [twfa_pkg::ANGLE_W-1:0]       measured_angle;
    logic [twfa_pkg::SPEED_W-1:0]       measured_speed;

    modport source (
        output valid, apparent_angle, apparent_speed, ground_speed,
               measured_angle, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, apparent_angle, apparent_speed, ground_speed,
               measured_angle, measured_speed,
        output ready
    );
endinterface

interface twfa_out_if;
    logic                           valid;
    logic                           ready;
    logic [twfa_pkg::ANGLE_W-1:0]   true_angle;
    logic [twfa_pkg::SPEED_W-1:0]   true_speed;
    logic                           angle_passed_through;
    logic                           speed_passed_through;

    modport source (
        output valid, true_angle, true_speed, angle_passed_through,
               speed_passed_through,
        input  ready
    );
    modport sink (
        input  valid, true_angle, true_speed, angle_passed_through,
               speed_passed_through,
        output ready
    );
endinterface

// ----- rtl/true_wind_from_apparent.sv -----
// True wind from apparent wind: fully pipelined two-pass CORDIC with output skid buffer.
//
// The block turns apparent wind angle and speed plus speed over ground into true
// wind angle and speed, all in tenths. A nonzero measured true angle or speed on
// the input is passed straight through (the angle reduced modulo 3600) and its
// flag is set; otherwise the value is computed. The computation is a rotation
// CORDIC that resolves the apparent vector into x and y, a gain correction, the
// subtraction of the ground speed from x, and a vectoring CORDIC that returns the
// angle (0..3599) and the length (saturated at 4095). A zero apparent speed or a
// zero resulting vector gives zero for every computed output. The pipeline takes
// one transaction per clock while the skid register is empty. Its registers are:
// one preparation stage, one register per CORDIC iteration in each pass, two
// multiply stages, a subtract stage, a fold stage and a final saturation stage.
// The whole pipeline advances on one enable; a single-entry skid register at
// the output catches the result that is on its way out when the consumer stalls,
// so the input stays ready in that cycle and only drops ready while the skid
// register holds a transaction. No state is kept between transactions, and
// reset only clears the valid bits.
module true_wind_from_apparent (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twfa_in_if.sink     i_in,
    twfa_out_if.source  o_out
);

    twfa_pkg::t_in_item     in_item;
    logic                   pipe_en;

    logic                   rot_valid;
    twfa_pkg::t_vec         rot_x;
    twfa_pkg::t_vec         rot_y;
    twfa_pkg::t_side        rot_side;

    logic                   vec_valid;
    twfa_pkg::t_vec         vec_x;
    twfa_pkg::t_vec         vec_z;
    twfa_pkg::t_side        vec_side;

    logic                   post_valid;
    twfa_pkg::t_out_item    post_item;

    logic                   r_skid_valid;
    twfa_pkg::t_out_item    r_skid_item;
    twfa_pkg::t_out_item    out_item;

    // The pipeline moves whenever the skid register is free to take a stalled result.
    assign pipe_en    = !r_skid_valid;
    assign i_in.ready = pipe_en;

    always_comb begin
        in_item.apparent_angle = i_in.apparent_angle;
        in_item.apparent_speed = i_in.apparent_speed;
        in_item.ground_speed   = i_in.ground_speed;
        in_item.measured_angle = i_in.measured_angle;
        in_item.measured_speed = i_in.measured_speed;
    end

    twfa_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_valid (rot_valid),
        .o_x     (rot_x),
        .o_y     (rot_y),
        .o_side  (rot_side)
    );

    twfa_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (rot_valid),
        .i_x     (rot_x),
        .i_y     (rot_y),
        .i_side  (rot_side),
        .o_valid (vec_valid),
        .o_x     (vec_x),
        .o_z     (vec_z),
        .o_side  (vec_side)
    );

    twfa_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (vec_valid),
        .i_x     (vec_x),
        .i_z     (vec_z),
        .i_side  (vec_side),
        .o_valid (post_valid),
        .o_item  (post_item)
    );

    // A result that is not taken while the pipeline advances moves into the skid
    // register; it leaves as soon as the consumer is ready, ahead of the result that
    // then sits frozen in the last pipeline stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (post_valid && !o_out.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_skid_item <= post_item;
        end
    end

    assign out_item                   = r_skid_valid ? r_skid_item : post_item;
    assign o_out.valid                = r_skid_valid | post_valid;
    assign o_out.true_angle           = out_item.true_angle;
    assign o_out.true_speed           = out_item.true_speed;
    assign o_out.angle_passed_through = out_item.angle_passed_through;
    assign o_out.speed_passed_through = out_item.speed_passed_through;

endmodule

// ----- rtl/twfa_rot.sv -----
// Input preparation and rotation-mode CORDIC pipeline (apparent vector to x/y).
module twfa_rot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  twfa_pkg::t_in_item  i_item,
    output logic                o_valid,
    output twfa_pkg::t_vec      o_x,
    output twfa_pkg::t_vec      o_y,
    output twfa_pkg::t_side     o_side
);

    logic               r_valid [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_vec     r_x     [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_vec     r_y     [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_vec     r_z     [twfa_pkg::CORDIC_STAGES];
    twfa_pkg::t_side    r_side  [twfa_pkg::CORDIC_STAGES+1];

    logic [twfa_pkg::ANGLE_W-1:0]       awa;
    logic signed [twfa_pkg::INT_W-1:0]  ang_int;
    logic                               flip;
    twfa_pkg::t_vec                     mag;
    twfa_pkg::t_vec                     n_x0;
    twfa_pkg::t_vec                     n_z0;
    twfa_pkg::t_side                    n_side0;

    // Fold the angle into -90..+90 degrees; the far half flips the start vector.
    always_comb begin
        awa = twfa_pkg::wrap_angle(i_item.apparent_angle);
        flip = 1'b0;
        if (awa > twfa_pkg::THREE_QUARTER) begin
            ang_int = $signed(twfa_pkg::INT_W'(awa)) - twfa_pkg::FULL_TURN;
        end else if (awa > twfa_pkg::QUARTER_TURN) begin
            ang_int = $signed(twfa_pkg::INT_W'(awa)) - twfa_pkg::HALF_TURN;
            flip    = 1'b1;
        end else begin
            ang_int = $signed(twfa_pkg::INT_W'(awa));
        end
        mag  = twfa_pkg::t_vec'(i_item.apparent_speed) <<< twfa_pkg::FRACTION_BITS;
        n_x0 = flip ? -mag : mag;
        n_z0 = twfa_pkg::t_vec'(ang_int) <<< twfa_pkg::FRACTION_BITS;

        n_side0.ground_speed = i_item.ground_speed;
        n_side0.force_zero   = (i_item.apparent_speed == '0);
        n_side0.angle_pass   = (i_item.measured_angle != '0);
        n_side0.angle_meas   = twfa_pkg::wrap_angle(i_item.measured_angle);
        n_side0.speed_pass   = (i_item.measured_speed != '0);
        n_side0.speed_meas   = i_item.measured_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_side[0] <= n_side0;
        end
    end

    for (genvar k = 0; k < twfa_pkg::CORDIC_STAGES; k++) begin : g_stage
        twfa_pkg::t_vec dx;
        twfa_pkg::t_vec dy;
        logic           up;

        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign up = !r_z[k][twfa_pkg::VW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= up ? (r_x[k] - dx) : (r_x[k] + dx);
                r_y[k+1]    <= up ? (r_y[k] + dy) : (r_y[k] - dy);
                r_side[k+1] <= r_side[k];
            end
        end

        if (k < twfa_pkg::CORDIC_STAGES - 1) begin : g_angle
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[k+1] <= up
                        ? (r_z[k] - twfa_pkg::atan_step(twfa_pkg::ATAN_IDX_W'(k)))
                        : (r_z[k] + twfa_pkg::atan_step(twfa_pkg::ATAN_IDX_W'(k)));
                end
            end
        end
    end

    assign o_valid = r_valid[twfa_pkg::CORDIC_STAGES];
    assign o_x     = r_x[twfa_pkg::CORDIC_STAGES];
    assign o_y     = r_y[twfa_pkg::CORDIC_STAGES];
    assign o_side  = r_side[twfa_pkg::CORDIC_STAGES];

endmodule

// ----- rtl/twfa_vec.sv -----
// Gain correction, ground speed removal and vectoring-mode CORDIC pipeline.
module twfa_vec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  twfa_pkg::t_vec      i_x,
    input  twfa_pkg::t_vec      i_y,
    input  twfa_pkg::t_side     i_side,
    output logic                o_valid,
    output twfa_pkg::t_vec      o_x,
    output twfa_pkg::t_vec      o_z,
    output twfa_pkg::t_side     o_side
);

    twfa_pkg::t_prod    prod_x;
    twfa_pkg::t_prod    prod_y;
    twfa_pkg::t_vec     sog_fx;
    logic               vec_zero;
    logic               vec_neg;
    twfa_pkg::t_side    n_side_f;

    logic               r_m_valid;
    twfa_pkg::t_vec     r_m_x;
    twfa_pkg::t_vec     r_m_y;
    twfa_pkg::t_side    r_m_side;

    logic               r_s_valid;
    twfa_pkg::t_vec     r_s_x;
    twfa_pkg::t_vec     r_s_y;
    twfa_pkg::t_side    r_s_side;

    logic               r_valid [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_vec     r_x     [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_vec     r_y     [twfa_pkg::CORDIC_STAGES];
    twfa_pkg::t_vec     r_z     [twfa_pkg::CORDIC_STAGES+1];
    twfa_pkg::t_side    r_side  [twfa_pkg::CORDIC_STAGES+1];

    assign prod_x = twfa_pkg::t_prod'(i_x) * twfa_pkg::t_prod'(twfa_pkg::INV_GAIN);
    assign prod_y = twfa_pkg::t_prod'(i_y) * twfa_pkg::t_prod'(twfa_pkg::INV_GAIN);
    assign sog_fx = twfa_pkg::t_vec'(r_m_side.ground_speed) <<< twfa_pkg::FRACTION_BITS;

    // The left half plane is mirrored and half a turn goes into the angle.
    always_comb begin
        vec_zero            = (r_s_x == '0) && (r_s_y == '0);
        vec_neg             = r_s_x[twfa_pkg::VW-1];
        n_side_f            = r_s_side;
        n_side_f.force_zero = r_s_side.force_zero | vec_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_s_valid  <= 1'b0;
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_m_valid  <= i_valid;
            r_s_valid  <= r_m_valid;
            r_valid[0] <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_x     <= prod_x[twfa_pkg::GAIN_SHIFT +: twfa_pkg::VW];
            r_m_y     <= prod_y[twfa_pkg::GAIN_SHIFT +: twfa_pkg::VW];
            r_m_side  <= i_side;

            r_s_x     <= r_m_x - sog_fx;
            r_s_y     <= r_m_y;
            r_s_side  <= r_m_side;

            r_x[0]    <= vec_neg ? -r_s_x : r_s_x;
            r_y[0]    <= vec_neg ? -r_s_y : r_s_y;
            r_z[0]    <= vec_neg
                ? (twfa_pkg::t_vec'(twfa_pkg::HALF_TURN) <<< twfa_pkg::FRACTION_BITS)
                : '0;
            r_side[0] <= n_side_f;
        end
    end

    for (genvar k = 0; k < twfa_pkg::CORDIC_STAGES; k++) begin : g_stage
        twfa_pkg::t_vec dx;
        logic           down;

        assign dx   = r_y[k] >>> k;
        assign down = r_y[k][twfa_pkg::VW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= down ? (r_x[k] - dx) : (r_x[k] + dx);
                r_z[k+1]    <= down
                    ? (r_z[k] - twfa_pkg::atan_step(twfa_pkg::ATAN_IDX_W'(k)))
                    : (r_z[k] + twfa_pkg::atan_step(twfa_pkg::ATAN_IDX_W'(k)));
                r_side[k+1] <= r_side[k];
            end
        end

        if (k < twfa_pkg::CORDIC_STAGES - 1) begin : g_y
            twfa_pkg::t_vec dy;

            assign dy = r_x[k] >>> k;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[k+1] <= down ? (r_y[k] + dy) : (r_y[k] - dy);
                end
            end
        end
    end

    assign o_valid = r_valid[twfa_pkg::CORDIC_STAGES];
    assign o_x     = r_x[twfa_pkg::CORDIC_STAGES];
    assign o_z     = r_z[twfa_pkg::CORDIC_STAGES];
    assign o_side  = r_side[twfa_pkg::CORDIC_STAGES];

endmodule

// ----- rtl/twfa_post.sv -----
// Angle wrap, speed gain and saturation, and selection of measured values.
module twfa_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  twfa_pkg::t_vec      i_x,
    input  twfa_pkg::t_vec      i_z,
    input  twfa_pkg::t_side     i_side,
    output logic                o_valid,
    output twfa_pkg::t_out_item o_item
);

    twfa_pkg::t_prod                        prod;
    twfa_pkg::t_vec                         n_t;

    logic                                   r_a_valid;
    twfa_pkg::t_vec                         r_t;
    twfa_pkg::t_prod                        r_p;
    twfa_pkg::t_side                        r_a_side;

    logic signed [twfa_pkg::INT_W-1:0]      ang_raw;
    logic [twfa_pkg::SPD_RAW_W-1:0]         spd_raw;
    logic [twfa_pkg::ANGLE_W-1:0]           ang;
    logic [twfa_pkg::SPEED_W-1:0]           spd;
    twfa_pkg::t_out_item                    n_item;

    logic                                   r_valid;
    twfa_pkg::t_out_item                    r_item;

    assign prod = twfa_pkg::t_prod'(i_x) * twfa_pkg::t_prod'(twfa_pkg::INV_GAIN);
    assign n_t  = i_z[twfa_pkg::VW-1]
        ? (i_z + (twfa_pkg::t_vec'(twfa_pkg::FULL_TURN) <<< twfa_pkg::FRACTION_BITS))
        : i_z;

    always_comb begin
        ang_raw = r_t[twfa_pkg::VW-1:twfa_pkg::FRACTION_BITS];
        spd_raw = r_p[twfa_pkg::PW-1:twfa_pkg::GAIN_SHIFT+twfa_pkg::FRACTION_BITS];

        if (ang_raw[twfa_pkg::INT_W-1]) begin
            ang = '0;
        end else if (ang_raw >= twfa_pkg::FULL_TURN) begin
            ang = twfa_pkg::ANGLE_W'(ang_raw - twfa_pkg::FULL_TURN);
        end else begin
            ang = twfa_pkg::ANGLE_W'(ang_raw);
        end

        if (spd_raw[twfa_pkg::SPD_RAW_W-1]) begin
            spd = '0;
        end else if (spd_raw > twfa_pkg::SPD_RAW_W'(twfa_pkg::SPEED_MAX)) begin
            spd = twfa_pkg::SPEED_MAX;
        end else begin
            spd = twfa_pkg::SPEED_W'(spd_raw);
        end

        n_item.angle_passed_through = r_a_side.angle_pass;
        n_item.speed_passed_through = r_a_side.speed_pass;
        if (r_a_side.angle_pass) begin
            n_item.true_angle = r_a_side.angle_meas;
        end else begin
            n_item.true_angle = r_a_side.force_zero ? '0 : ang;
        end
        if (r_a_side.speed_pass) begin
            n_item.true_speed = r_a_side.speed_meas;
        end else begin
            n_item.true_speed = r_a_side.force_zero ? '0 : spd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= n_t;
            r_p      <= prod;
            r_a_side <= i_side;
            r_item   <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/twfa_checker.sv -----
// Port-level checker for the true wind block, bound to the top level.
`include "true_wind_from_apparent_assert.svh"

module twfa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [twfa_pkg::ANGLE_W-1:0]     i_true_angle,
    input logic [twfa_pkg::SPEED_W-1:0]     i_true_speed,
    input logic                             i_angle_pass,
    input logic                             i_speed_pass
);

    // A stalled result stays on the port unchanged.
    `TWFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_true_angle) && $stable(i_true_speed) && $stable(i_angle_pass) && $stable(i_speed_pass))

    // Reset empties the pipeline and the skid register.
    `TWFA_ASSERT_RESET(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

    // Input backpressure only happens while a buffered result is waiting.
    `TWFA_ASSERT_IMPL(a_backpressure, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // Ready only drops right after a result was refused.
    `TWFA_ASSERT_IMPL(a_ready_drop, i_clk, i_rst_n, $fell(i_in_ready), $past(i_out_valid && !i_out_ready))

    // Every delivered angle is already reduced to one turn.
    `TWFA_ASSERT_IMPL(a_angle_range, i_clk, i_rst_n, i_out_valid, i_true_angle < twfa_pkg::ANGLE_WRAP)

endmodule

bind true_wind_from_apparent twfa_checker u_twfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_true_angle (o_out.true_angle),
    .i_true_speed (o_out.true_speed),
    .i_angle_pass (o_out.angle_passed_through),
    .i_speed_pass (o_out.speed_passed_through)
);

// ----- tb/sv/true_wind_from_apparent_checker.sv -----
// Scoreboard that predicts every true wind result and checks the block's output channel.
module true_wind_from_apparent_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    twfa_in_if   i_in,
    twfa_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import twfa_pkg::*;

    localparam longint UNIT         = longint'(1) << FRACTION_BITS;
    localparam longint INV_GAIN_Q24 = 10188014;
    localparam int     GAIN_FRAC    = 24;
    localparam int     TABLE_LEN    = 24;
    localparam int     STEP_COUNT   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int     ROUND_SHIFT  = 16 - FRACTION_BITS;
    localparam longint TURN_TENTHS  = 3600;
    localparam longint HALF_TENTHS  = 1800;
    localparam longint RIGHT_ANGLE  = 900;
    localparam longint LAST_QUARTER = 2700;
    localparam longint SPEED_LIMIT  = 4095;

    // Elementary rotation angles atan(2^-i), tenths of a degree scaled by 2^16.
    localparam longint ARCTAN_Q16 [TABLE_LEN] = '{
        29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
        146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
        573, 286, 143, 72, 36, 18, 9, 4
    };

    function automatic longint arctan_step(input int idx);
        longint half;
        half = (longint'(1) << ROUND_SHIFT) >>> 1;
        return (ARCTAN_Q16[idx] + half) >>> ROUND_SHIFT;
    endfunction

    // Resolves the apparent vector, removes the boat's own motion and measures what is left.
    function automatic void solve_wind(input longint awa_in, input longint aws,
                                       input longint sog,
                                       output longint angle, output longint speed);
        longint awa, x, y, z, dx, dy, base, t;
        int     i;
        awa  = awa_in;
        x    = aws * UNIT;
        y    = 0;
        base = 0;
        if (awa > LAST_QUARTER) begin
            awa = awa - TURN_TENTHS;
        end else if (awa > RIGHT_ANGLE) begin
            awa = awa - HALF_TENTHS;
            x   = -x;
        end
        z = awa * UNIT;
        for (i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end else begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end
        end
        x = ((x * INV_GAIN_Q24) >>> GAIN_FRAC) - sog * UNIT;
        y = (y * INV_GAIN_Q24) >>> GAIN_FRAC;

        if (x == 0 && y == 0) begin
            angle = 0;
            speed = 0;
            return;
        end
        if (x < 0) begin
            x    = -x;
            y    = -y;
            base = HALF_TENTHS * UNIT;
        end
        z = 0;
        for (i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end else begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end
        end
        t = base + z;
        if (t < 0) t = t + TURN_TENTHS * UNIT;
        t = t >>> FRACTION_BITS;
        if (t < 0) t = 0;
        angle = t % TURN_TENTHS;

        speed = (x * INV_GAIN_Q24) >>> (GAIN_FRAC + FRACTION_BITS);
        if (speed < 0) speed = 0;
        if (speed > SPEED_LIMIT) speed = SPEED_LIMIT;
    endfunction

    function automatic t_out_item predict_true_wind(input t_in_item s);
        t_out_item          r;
        logic [ANGLE_W-1:0] awa, meas_angle;
        longint             c_angle, c_speed;
        awa        = (s.apparent_angle >= TURN_TENTHS) ?
                     ANGLE_W'(s.apparent_angle - TURN_TENTHS) : s.apparent_angle;
        meas_angle = (s.measured_angle >= TURN_TENTHS) ?
                     ANGLE_W'(s.measured_angle - TURN_TENTHS) : s.measured_angle;
        c_angle = 0;
        c_speed = 0;
        if (s.apparent_speed != 0 && (s.measured_angle == 0 || s.measured_speed == 0))
            solve_wind(longint'(awa), longint'(s.apparent_speed), longint'(s.ground_speed),
                       c_angle, c_speed);
        if (s.measured_angle != 0) begin
            r.true_angle           = meas_angle;
            r.angle_passed_through = 1'b1;
        end else begin
            r.true_angle           = c_angle[ANGLE_W-1:0];
            r.angle_passed_through = 1'b0;
        end
        if (s.measured_speed != 0) begin
            r.true_speed           = s.measured_speed;
            r.speed_passed_through = 1'b1;
        end else begin
            r.true_speed           = c_speed[SPEED_W-1:0];
            r.speed_passed_through = 1'b0;
        end
        return r;
    endfunction

    t_out_item expected_winds[$];
    int        mismatches = 0;
    int        results_seen = 0;

    always @(posedge i_clk) begin : scoreboard
        t_in_item  sample;
        t_out_item want, got;
        if (!i_rst_n) begin
            expected_winds.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                sample.apparent_angle = i_in.apparent_angle;
                sample.apparent_speed = i_in.apparent_speed;
                sample.ground_speed   = i_in.ground_speed;
                sample.measured_angle = i_in.measured_angle;
                sample.measured_speed = i_in.measured_speed;
                expected_winds.push_back(predict_true_wind(sample));
            end
            if (i_out.valid && i_out.ready) begin
                got.true_angle           = i_out.true_angle;
                got.true_speed           = i_out.true_speed;
                got.angle_passed_through = i_out.angle_passed_through;
                got.speed_passed_through = i_out.speed_passed_through;
                results_seen++;
                if (expected_winds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: angle %0d speed %0d",
                                 $realtime, got.true_angle, got.true_speed);
                end else begin
                    want = expected_winds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected angle %0d speed %0d flags %b%b, ",
                                      "got angle %0d speed %0d flags %b%b"}, $realtime,
                                     want.true_angle, want.true_speed,
                                     want.angle_passed_through, want.speed_passed_through,
                                     got.true_angle, got.true_speed,
                                     got.angle_passed_through, got.speed_passed_through);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_winds.size();
        o_checked    <= results_seen;
    end

endmodule

// ----- tb/sv/true_wind_from_apparent_tb.sv -----
// Top of the true wind testbench: clock, reset, stimulus, output pacing and the verdict.
module true_wind_from_apparent_tb;
    import twfa_pkg::*;

    localparam int HALF_PERIOD  = 6;
    // Pipeline depth of the block: 2 * stages + 6.
    localparam int LATENCY      = 2 * CORDIC_STAGES + 6;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES       = 3;
    // Even with heavy stalls on both sides a full run stays far below this.
    localparam int LIMIT_CYCLES = 300000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Percentages of cycles in which the sender holds back a transaction and the
    // receiver refuses one. They change from phase to phase.
    int sender_idle_pct    = 12;
    int receiver_stall_pct = 84;

    int fail_count, pending, checked;
    int sent_count         = 0;
    int measured_angle_cnt = 0;
    int measured_speed_cnt = 0;
    int calm_cnt           = 0;

    twfa_in_if  in_ch ();
    twfa_out_if out_ch ();

    true_wind_from_apparent dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    true_wind_from_apparent_checker u_wind_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The receiver draws a fresh ready every cycle, so stalls land on every
    // stage of the pipeline and on the skid register at the output.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Presents one transaction, idling at random beforehand, and returns once
    // it has been accepted at a clock edge.
    task automatic send_sample(input t_in_item s);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.apparent_angle <= s.apparent_angle;
        in_ch.apparent_speed <= s.apparent_speed;
        in_ch.ground_speed   <= s.ground_speed;
        in_ch.measured_angle <= s.measured_angle;
        in_ch.measured_speed <= s.measured_speed;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
        if (s.measured_angle != 0) measured_angle_cnt++;
        if (s.measured_speed != 0) measured_speed_cnt++;
        if (s.apparent_speed == 0) calm_cnt++;
    endtask

    task automatic send_fields(input int awa, input int aws, input int sog,
                               input int meas_angle, input int meas_speed);
        t_in_item s;
        s.apparent_angle = ANGLE_W'(awa);
        s.apparent_speed = SPEED_IN_W'(aws);
        s.ground_speed   = SPEED_IN_W'(sog);
        s.measured_angle = ANGLE_W'(meas_angle);
        s.measured_speed = SPEED_W'(meas_speed);
        send_sample(s);
    endtask

    // Stops sending and waits until the scoreboard has seen every result that
    // is owed. The first edge lets the count pick up the last acceptance.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly computed wind with the angle anywhere on the circle; some samples
    // sit on the quadrant folds, some use out-of-range angle codes, some have
    // no apparent wind or a ground speed equal to it, about a quarter carry a
    // measured angle and about a quarter a measured speed that must be passed through.
    function automatic t_in_item random_sample();
        t_in_item s;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            s.apparent_angle = ANGLE_W'($urandom_range(3600, 4095));
        else if (pick < 18)
            s.apparent_angle = ANGLE_W'(($urandom_range(0, 3) * 900 + 3599
                                         + $urandom_range(0, 2)) % 3600);
        else
            s.apparent_angle = ANGLE_W'($urandom_range(0, 3599));

        s.apparent_speed = ($urandom_range(0, 99) < 8) ? '0 : SPEED_IN_W'($urandom_range(1, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            s.ground_speed = s.apparent_speed;
        else if (pick < 20)
            s.ground_speed = '0;
        else
            s.ground_speed = SPEED_IN_W'($urandom_range(0, 2047));

        s.measured_angle = ($urandom_range(0, 99) < 75) ? '0 : ANGLE_W'($urandom_range(1, 4095));
        s.measured_speed = ($urandom_range(0, 99) < 75) ? '0 : SPEED_W'($urandom_range(1, 4095));
        return s;
    endfunction

    initial begin : stimulus
        int phase;
        in_ch.valid          = 1'b0;
        in_ch.apparent_angle = '0;
        in_ch.apparent_speed = '0;
        in_ch.ground_speed   = '0;
        in_ch.measured_angle = '0;
        in_ch.measured_speed = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed transactions. Calm air, with and without boat speed.
        send_fields(0,    0,    0,    0,    0);
        send_fields(1800, 0,    2047, 0,    0);
        // Strongest apparent wind, and the angles on either side of each fold
        // of the rotation into -90..+90 degrees.
        send_fields(0,    2047, 0,    0,    0);
        send_fields(900,  2047, 2047, 0,    0);
        send_fields(901,  1000, 0,    0,    0);
        send_fields(1800, 2047, 2047, 0,    0);
        send_fields(2700, 500,  100,  0,    0);
        send_fields(2701, 500,  100,  0,    0);
        send_fields(3599, 2047, 0,    0,    0);
        // Angle codes above 3599 must wrap back by a full turn.
        send_fields(3600, 300,  50,   0,    0);
        send_fields(4095, 300,  50,   0,    0);
        // Ground speed cancels the apparent wind, or nearly does.
        send_fields(0,    500,  500,  0,    0);
        send_fields(0,    1,    1,    0,    0);
        send_fields(0,    1,    0,    0,    0);
        // Measured values passed through, one or both, including a measured
        // angle that wraps to zero while its flag stays set.
        send_fields(0,    0,    0,    1,    0);
        send_fields(1234, 700,  300,  3599, 4095);
        send_fields(2000, 800,  100,  3600, 0);
        send_fields(500,  900,  900,  4095, 1);
        send_fields(1234, 2047, 0,    0,    4095);
        send_fields(3000, 0,    1500, 1234, 0);
        // Diagonal headings, mostly with the largest speeds the inputs allow.
        send_fields(450,  2047, 2047, 0,    0);
        send_fields(1350, 2047, 0,    0,    0);
        send_fields(3150, 1024, 2047, 0,    0);
        send_fields(2250, 2047, 1024, 0,    0);

        // Random traffic in three pacing phases. Each phase ends with the
        // sender holding off until the pipeline has fully drained.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 12;
                    receiver_stall_pct = 84;
                end
                1: begin
                    sender_idle_pct    = 84;
                    receiver_stall_pct = 12;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            repeat ((RANDOM_ITEMS + PHASES - 1) / PHASES) send_sample(random_sample());
            drain_results();
        end

        // Anything the block emits after the last expected result is a failure,
        // so give it a full pipeline depth to show up.
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d transactions and checked %0d results over three pacing phases.",
                 sent_count, checked);
        $display("Of these %0d carried a measured angle, %0d a measured speed, %0d calm air.",
                 measured_angle_cnt, measured_speed_cnt, calm_cnt);
        if (fail_count == 0)
            $display("PASS true_wind_from_apparent");
        else
            $display("FAIL true_wind_from_apparent");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Run did not complete in time; %0d results still outstanding.", pending);
        $display("FAIL true_wind_from_apparent");
        $finish;
    end

endmodule
